// ===== src/shab_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte hasher.
package shab_pkg;

    localparam int unsigned QueueDepth = 4;

    typedef enum logic [1:0] {
        CMD_ABSORB        = 2'd0,
        CMD_ABSORB_FINISH = 2'd1,
        CMD_FINISH        = 2'd2,
        CMD_NONE          = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_word;

    typedef struct packed {
        logic       push_byte;
        logic       finish;
        logic [7:0] data_byte;
    } t_op;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] w;
        unique case (idx)
            3'd0: w = 32'h6a09e667;
            3'd1: w = 32'hbb67ae85;
            3'd2: w = 32'h3c6ef372;
            3'd3: w = 32'ha54ff53a;
            3'd4: w = 32'h510e527f;
            3'd5: w = 32'h9b05688c;
            3'd6: w = 32'h1f83d9ab;
            default: w = 32'h5be0cd19;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[idx];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
        return (x >> r) | (x << (32 - r));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== src/shab_front.sv =====
// Front end: classifies commands and queues byte and finish operations.
module shab_front #(
    parameter int unsigned DEPTH = shab_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  shab_pkg::t_in_word i_word,
    output logic               o_op_valid,
    input  logic               i_op_ready,
    output shab_pkg::t_op      o_op
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    shab_pkg::t_op r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;
    shab_pkg::t_op w_op;

    always_comb begin
        w_op.data_byte = i_word.data_byte;
        w_op.push_byte = 1'b0;
        w_op.finish    = 1'b0;
        unique case (shab_pkg::t_cmd'(i_word.command))
            shab_pkg::CMD_ABSORB: begin
                w_op.push_byte = 1'b1;
            end
            shab_pkg::CMD_ABSORB_FINISH: begin
                w_op.push_byte = 1'b1;
                w_op.finish    = 1'b1;
            end
            shab_pkg::CMD_FINISH: begin
                w_op.finish = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_ready    = (r_cnt != (AW+1)'(DEPTH));
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_mem[r_rd];
    assign w_push     = i_valid && o_ready && (w_op.push_byte || w_op.finish);
    assign w_pop      = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wr] <= w_op;
        end
    end

endmodule

// ===== src/shab_core.sv =====
// Back end: byte buffer, padding sequencer, round engine and digest output.
module shab_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    output logic                o_op_ready,
    input  shab_pkg::t_op       i_op,
    output logic                o_valid,
    input  logic                i_ready,
    output shab_pkg::t_out_word o_word
);

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [63:0] r_bits;
    logic [5:0]  r_rnd;
    logic        r_fin;
    logic        r_pad_first;
    logic        r_len_blk;
    logic [1:0]  r_oidx;
    logic        r_ovalid;

    logic [7:0]  w_pad_byte;
    logic [31:0] w_t1, w_t2, w_wnext;

    assign o_op_ready = (r_state == S_IDLE);
    assign o_valid    = r_ovalid;

    always_comb begin
        if (r_pad_first) begin
            w_pad_byte = 8'h80;
        end else if (r_len_blk && r_fill >= 6'd56) begin
            w_pad_byte = r_bits[63 - 8*(r_fill - 6'd56) -: 8];
        end else begin
            w_pad_byte = 8'h00;
        end
        w_t1 = r_v[7] + shab_pkg::bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + shab_pkg::round_const(r_rnd) + r_w[0];
        w_t2 = shab_pkg::bsig0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_wnext = shab_pkg::sig1(r_w[14]) + r_w[9] + shab_pkg::sig0(r_w[1]) + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_len     <= '0;
            r_fin     <= 1'b0;
            r_len_blk <= 1'b0;
            r_ovalid  <= 1'b0;
            r_oidx    <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= shab_pkg::init_word(3'(i));
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_op_valid) begin
                        if (i_op.push_byte) begin
                            r_w[r_fill[5:2]] <= {r_w[r_fill[5:2]][23:0], i_op.data_byte};
                            r_fill <= r_fill + 1'b1;
                            r_len  <= r_len + 64'd1;
                        end
                        r_fin       <= i_op.finish;
                        r_pad_first <= 1'b1;
                        r_len_blk   <= 1'b0;
                        r_bits      <= (r_len + 64'(i_op.push_byte)) << 3;
                        if (i_op.push_byte && r_fill == 6'd63) begin
                            r_state <= S_LOAD;
                        end else if (i_op.finish) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_w[r_fill[5:2]] <= {r_w[r_fill[5:2]][23:0], w_pad_byte};
                    r_fill      <= r_fill + 1'b1;
                    r_pad_first <= 1'b0;
                    if (r_pad_first) begin
                        r_len_blk <= (r_fill < 6'd56);
                    end
                    if (r_fill == 6'd63) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= r_h[i];
                    end
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_v[0] <= w_t1 + w_t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_wnext;
                    r_rnd   <= r_rnd + 1'b1;
                    if (r_rnd == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_len_blk) begin
                        r_oidx   <= '0;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_len_blk <= !r_pad_first;
                        r_state   <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 2'd3) begin
                            r_ovalid <= 1'b0;
                            r_fill   <= '0;
                            r_len    <= '0;
                            r_fin    <= 1'b0;
                            r_state  <= S_IDLE;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= shab_pkg::init_word(3'(i));
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_word.digest_word = {r_h[{r_oidx, 1'b0}], r_h[{r_oidx, 1'b1}]};
        o_word.word_index  = r_oidx;
        o_word.last_word   = (r_oidx == 2'd3);
    end

endmodule

// ===== src/sha256_byte_hasher.sv =====
// SHA-256 byte hasher top level: front end queue feeding the compression back end.
// A byte that does not complete a block is stored in the buffer. A byte that completes
// a block starts a compression (load, 64 rounds of one round per cycle, final add);
// finishing pads one byte per cycle through the length field and runs one or two
// compressions, then offers four digest words. A four-entry queue lets input words
// be taken while the round engine works.
module sha256_byte_hasher #(
    parameter int unsigned QUEUE_DEPTH = shab_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  shab_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output shab_pkg::t_out_word o_word
);

    logic          w_op_valid, w_op_ready;
    shab_pkg::t_op w_op;

    shab_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_word,
        .o_op_valid(w_op_valid), .i_op_ready(w_op_ready), .o_op(w_op)
    );

    shab_core u_core (
        .i_clk, .i_rst_n,
        .i_op_valid(w_op_valid), .o_op_ready(w_op_ready), .i_op(w_op),
        .o_valid, .i_ready, .o_word
    );

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.last_word == (o_word.word_index == 2'd3)))
        else $error("last_word mismatch");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_word.last_word) |=>
        (o_valid && o_word.word_index == $past(o_word.word_index) + 2'd1))
        else $error("digest word order broken");

    a_no_op_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_op_ready)
        else $error("op taken during digest output");

endmodule
